/* rtl/core/m9bd_pkg.sv */
// Shared types, constants and register codes of the median button debouncer.
package m9bd_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int WINDOW_DEFAULT = 9;
    localparam int ADC_BITS       = 12;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE =
        (ADC_BITS >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                               : SAMPLE_W'((1 << ADC_BITS) - 1);

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median_sample;
        logic                pressed;
        logic                reading_usable;
    } out_t;

    typedef struct packed {
        logic                gt;
        logic                valid;
        logic [SAMPLE_W-1:0] val;
    } link_t;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } st_t;

endpackage

/* rtl/core/m9bd_sort_cell.sv */
// One cell of the insertion sorter: holds one sorted sample, shifts up on insert.
module m9bd_sort_cell
    import m9bd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                insert,
    input  logic [SAMPLE_W-1:0] x,
    input  link_t               left,
    output link_t               right
);

    logic                valid_reg;
    logic                valid_next;
    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;
    logic                gt;

    assign gt = !valid_reg || (val_reg > x);

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (insert && gt)
        begin
            if (left.gt)
            begin
                valid_next = left.valid;
                val_next   = left.val;
            end
            else
            begin
                valid_next = 1'b1;
                val_next   = x;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign right.gt    = gt;
    assign right.valid = valid_reg;
    assign right.val   = val_reg;

endmodule

/* rtl/core/m9bd_button.sv */
// Hysteresis button detector with two-median confirm and time debounce.
module m9bd_button
    import m9bd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [SAMPLE_W-1:0]   med,
    input  logic [TIME_W-1:0]     now,
    input  logic [SAMPLE_W-1:0]   press_thr,
    input  logic [SAMPLE_W-1:0]   release_thr,
    input  logic [DEBOUNCE_W-1:0] debounce,
    output out_t                  result
);

    logic              pressed_reg;
    logic              pressed_next;
    logic              cand_reg;
    logic              cand_next;
    logic [TIME_W-1:0] since_reg;
    logic [TIME_W-1:0] since_next;
    logic [SAMPLE_W-1:0] rel_thr;
    logic              want;
    logic [TIME_W-1:0] elapsed;

    assign rel_thr = (release_thr > press_thr) ? release_thr : press_thr;
    assign elapsed = now - since_reg;

    always_comb
    begin
        if (!pressed_reg)
        begin
            want = (med <= press_thr);
        end
        else
        begin
            want = !(med >= rel_thr);
        end
    end

    always_comb
    begin
        pressed_next = pressed_reg;
        cand_next    = cand_reg;
        since_next   = since_reg;
        if (want == pressed_reg)
        begin
            cand_next  = pressed_reg;
            since_next = '0;
        end
        else if (cand_reg != want)
        begin
            cand_next  = want;
            since_next = now;
        end
        else if ((debounce == '0) || (elapsed >= TIME_W'(debounce)))
        begin
            pressed_next = want;
            since_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            cand_reg    <= 1'b0;
            since_reg   <= '0;
        end
        else if (en)
        begin
            pressed_reg <= pressed_next;
            cand_reg    <= cand_next;
            since_reg   <= since_next;
        end
    end

    assign result.median_sample  = med;
    assign result.pressed        = pressed_next;
    assign result.reading_usable = !pressed_next && (med != '0) && (med < FULL_SCALE);

endmodule

/* rtl/core/median9_button_debouncer.sv */
// Top level: window sorter chain, button detector, output register and config.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | in_data  (sample, now_ms)
//  out     | output    | out_valid / out_ready   | out_data (median, pressed, usable)
//  cfg     | input     | cfg_we                  | cfg_index, cfg_data
//
// Each sample is inserted into the sorter chain as it is accepted; the last sample
// of a window is followed by an evaluate state in which the detector updates and
// the result loads the output register, and no input is accepted meanwhile.
// Reset clears the sorter valid bits, the window count and the detector state.
// A full output register stalls the evaluate cycle, and with it the input.
module median9_button_debouncer
    import m9bd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW - 1);
    localparam int MID = WINDOW / 2;

    st_t                   state_reg;
    st_t                   state_next;
    logic [CNT_W-1:0]      fill_reg;
    logic [CNT_W-1:0]      fill_next;
    logic [TIME_W-1:0]     now_reg;
    logic [SAMPLE_W-1:0]   press_reg;
    logic [SAMPLE_W-1:0]   release_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_t                  out_data_reg;
    out_t                  result;
    logic                  in_xfer;
    logic                  commit;
    logic [SAMPLE_W-1:0]   x;
    link_t                 link [WINDOW+1];

    assign in_xfer = in_valid && in_ready;
    assign x = (in_data.sample > FULL_SCALE) ? FULL_SCALE : in_data.sample;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (fill_reg == LAST))
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EVAL:
            begin
                commit = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (in_xfer)
        begin
            fill_next = (fill_reg == LAST) ? '0 : fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            press_reg     <= '0;
            release_reg   <= '0;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PRESS:    press_reg    <= cfg_data[SAMPLE_W-1:0];
                    REG_RELEASE:  release_reg  <= cfg_data[SAMPLE_W-1:0];
                    REG_DEBOUNCE: debounce_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            now_reg <= in_data.now_ms;
        end
        if (commit)
        begin
            out_data_reg <= result;
        end
    end

    assign link[0].gt    = 1'b0;
    assign link[0].valid = 1'b0;
    assign link[0].val   = '0;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        m9bd_sort_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .clear  (commit),
            .insert (in_xfer),
            .x      (x),
            .left   (link[i]),
            .right  (link[i+1])
        );
    end

    m9bd_button u_button (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (commit),
        .med         (link[MID+1].val),
        .now         (now_reg),
        .press_thr   (press_reg),
        .release_thr (release_reg),
        .debounce    (debounce_reg),
        .result      (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
